// ----- sv/pwirt_pkg.sv -----
package pwirt_pkg;

    // Widths fixed by the word formats.
    localparam int DATA_W     = 32;
    localparam int DATA_IDX_W = 5;
    localparam int COUNT_W    = 6;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 2;

    // Request codes carried in req_type.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_SEND = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ONE  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ZERO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE     = 2'd3;

    localparam logic [CFG_W-1:0] CFG_RESET = 8'd1;

    typedef struct packed {
        logic               req_type;
        logic [DATA_W-1:0]  data_word;
        logic [COUNT_W-1:0] bit_count;
    } in_word_t;

    typedef struct packed {
        logic carrier_on;
        logic tx_enable;
        logic frame_done;
    } out_word_t;

    typedef struct packed {
        logic [CFG_W-1:0] header_ticks;
        logic [CFG_W-1:0] mark_one_ticks;
        logic [CFG_W-1:0] mark_zero_ticks;
        logic [CFG_W-1:0] space_ticks;
    } cfg_regs_t;

endpackage

// ----- sv/pulse_width_ir_transmitter.sv -----
// Pulse-width coded infrared transmitter.
//
// Input channel (in_valid/in_ready/in_word): each word is either a send
// request, which loads data_word and bit_count and raises tx_enable, or a
// timer tick, which advances the frame by one tick. The frame is a header
// mark, one mark per bit (most significant counted bit first), and a space
// after every mark; carrier_on is high during marks.
// Output channel (out_valid/out_ready/out_word): exactly one result word per
// input word, in order, showing carrier_on, tx_enable and frame_done.
// Configuration: cfg_write with cfg_index/cfg_data writes one of the four
// length registers at once; write only while no words are in flight.
// Each accepted word is held in the input register, then passes through the
// combinational frame update into the result register, which drives
// out_valid. Throughput is one word per clock while out_ready stays high: the
// input register and the result register each hold one word.
// When out_ready is low the result register holds its word, the input
// register fills, and in_ready drops only once both are full.
// Reset clears the frame state and the valid flags of both pipeline registers
// (their payloads carry no reset) and sets every length register to one tick.
module pulse_width_ir_transmitter import pwirt_pkg::*; #(
    parameter int MAX_BITS       = 32,
    parameter int DURATION_WIDTH = 8
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_word_t            out_word,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    logic      in_valid_reg;
    in_word_t  in_word_reg;
    logic      out_valid_reg;
    out_word_t out_word_reg;
    cfg_regs_t cfg_reg;
    out_word_t result;
    logic      step;

    // The staged word moves on whenever the result register is free or
    // being emptied this cycle.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_ticks    <= CFG_RESET;
            cfg_reg.mark_one_ticks  <= CFG_RESET;
            cfg_reg.mark_zero_ticks <= CFG_RESET;
            cfg_reg.space_ticks     <= CFG_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_HEADER:    cfg_reg.header_ticks    <= cfg_data;
                CFG_MARK_ONE:  cfg_reg.mark_one_ticks  <= cfg_data;
                CFG_MARK_ZERO: cfg_reg.mark_zero_ticks <= cfg_data;
                CFG_SPACE:     cfg_reg.space_ticks     <= cfg_data;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (step)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            in_word_reg <= in_word;
        end
        if (step)
        begin
            out_word_reg <= result;
        end
    end

    pwirt_core #(
        .MAX_BITS       (MAX_BITS),
        .DURATION_WIDTH (DURATION_WIDTH)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_word_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ----- sv/pwirt_core.sv -----
module pwirt_core import pwirt_pkg::*; #(
    parameter int MAX_BITS       = 32,
    parameter int DURATION_WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  in_word_t  word,
    input  cfg_regs_t cfg,
    output out_word_t result
);

    localparam int TOTAL_W = $clog2(MAX_BITS + 1);
    localparam int POS_W   = $clog2(MAX_BITS + 2);
    localparam int SEL_W   = (POS_W > COUNT_W) ? POS_W : COUNT_W;

    logic [DATA_W-1:0]         shift_word_reg, shift_word_next;
    logic [TOTAL_W-1:0]        bit_total_reg, bit_total_next;
    logic [POS_W-1:0]          bit_position_reg, bit_position_next;
    logic                      in_mark_reg, in_mark_next;
    logic [DURATION_WIDTH-1:0] tick_count_reg, tick_count_next;
    logic [DURATION_WIDTH-1:0] target_ticks_reg, target_ticks_next;
    logic                      start_pending_reg, start_pending_next;
    logic                      running_reg, running_next;
    logic                      carrier_reg, carrier_next;
    logic                      enable_reg, enable_next;
    logic                      done;

    logic [DURATION_WIDTH-1:0] header_dur, one_dur, zero_dur, space_dur;
    logic [POS_W-1:0]          pos_inc;
    logic [SEL_W-1:0]          bit_idx;
    logic                      next_bit;
    logic [SEL_W-1:0]          count_wide;
    logic [TOTAL_W-1:0]        count_sat;

    // Lengths wrap at the tick counter width.
    assign header_dur = DURATION_WIDTH'(cfg.header_ticks);
    assign one_dur    = DURATION_WIDTH'(cfg.mark_one_ticks);
    assign zero_dur   = DURATION_WIDTH'(cfg.mark_zero_ticks);
    assign space_dur  = DURATION_WIDTH'(cfg.space_ticks);

    assign count_wide = SEL_W'(word.bit_count);
    assign count_sat  = (count_wide > SEL_W'(MAX_BITS)) ? TOTAL_W'(MAX_BITS)
                                                         : TOTAL_W'(word.bit_count);

    // Bit sent at the next position; bits above the data word go out as zero.
    assign pos_inc  = bit_position_reg + 1'b1;
    assign bit_idx  = SEL_W'(bit_total_reg) - SEL_W'(pos_inc);
    assign next_bit = (bit_idx < SEL_W'(DATA_W)) ? shift_word_reg[bit_idx[DATA_IDX_W-1:0]]
                                                  : 1'b0;

    always_comb
    begin
        shift_word_next    = shift_word_reg;
        bit_total_next     = bit_total_reg;
        bit_position_next  = bit_position_reg;
        in_mark_next       = in_mark_reg;
        tick_count_next    = tick_count_reg;
        target_ticks_next  = target_ticks_reg;
        start_pending_next = start_pending_reg;
        running_next       = running_reg;
        carrier_next       = carrier_reg;
        enable_next        = enable_reg;
        done               = 1'b0;

        if (word.req_type == REQ_SEND)
        begin
            shift_word_next    = word.data_word;
            bit_total_next     = count_sat;
            bit_position_next  = '0;
            enable_next        = 1'b1;
            target_ticks_next  = header_dur;
            in_mark_next       = 1'b1;
            start_pending_next = 1'b1;
        end
        else
        begin
            if (start_pending_reg)
            begin
                carrier_next       = 1'b1;
                start_pending_next = 1'b0;
                tick_count_next    = '0;
                running_next       = 1'b1;
            end
            if (running_next)
            begin
                tick_count_next = tick_count_next + 1'b1;
                if (tick_count_next == target_ticks_reg)
                begin
                    tick_count_next = '0;
                    in_mark_next    = ~in_mark_reg;
                    if (in_mark_reg)
                    begin
                        carrier_next      = 1'b0;
                        target_ticks_next = space_dur;
                    end
                    else if (SEL_W'(pos_inc) > SEL_W'(bit_total_reg))
                    begin
                        // Space after the last bit is over: the frame ends.
                        enable_next       = 1'b0;
                        carrier_next      = 1'b0;
                        bit_position_next = '0;
                        running_next      = 1'b0;
                        done              = 1'b1;
                        target_ticks_next = header_dur;
                    end
                    else
                    begin
                        bit_position_next = pos_inc;
                        carrier_next      = 1'b1;
                        target_ticks_next = next_bit ? one_dur : zero_dur;
                    end
                end
            end
        end
    end

    assign result.carrier_on = carrier_next;
    assign result.tx_enable  = enable_next;
    assign result.frame_done = done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_word_reg    <= '0;
            bit_total_reg     <= '0;
            bit_position_reg  <= '0;
            in_mark_reg       <= 1'b0;
            tick_count_reg    <= '0;
            target_ticks_reg  <= '0;
            start_pending_reg <= 1'b0;
            running_reg       <= 1'b0;
            carrier_reg       <= 1'b0;
            enable_reg        <= 1'b0;
        end
        else if (step)
        begin
            shift_word_reg    <= shift_word_next;
            bit_total_reg     <= bit_total_next;
            bit_position_reg  <= bit_position_next;
            in_mark_reg       <= in_mark_next;
            tick_count_reg    <= tick_count_next;
            target_ticks_reg  <= target_ticks_next;
            start_pending_reg <= start_pending_next;
            running_reg       <= running_next;
            carrier_reg       <= carrier_next;
            enable_reg        <= enable_next;
        end
    end

endmodule

// ----- sv/pwirt_checker.sv -----
module pwirt_checker import pwirt_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    input logic      in_ready,
    input logic      out_valid,
    input logic      out_ready,
    input out_word_t out_word
);

    // A stalled result word stays put.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("result word changed while stalled");

    // The carrier only runs inside an enabled frame.
    a_carrier_enabled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.carrier_on |-> out_word.tx_enable)
        else $error("carrier on without enable");

    // The word that ends a frame shows carrier and enable both dropped.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_word.frame_done |-> !out_word.tx_enable && !out_word.carrier_on)
        else $error("frame_done with carrier or enable still high");

    // The input side only stalls behind a result word that is itself stalled.
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled while the result side was free");

endmodule

bind pulse_width_ir_transmitter pwirt_checker u_pwirt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
);
